/* hdl/tlg_pkg.sv */
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types and constants for the thermal level guard: level and
// simulation codes, register indexes, reset values and the item records.
// ----------------------------------------------------------------------------
package tlg_pkg;

   localparam int TEMP_W      = 16;
   localparam int DEG_W       = 8;
   localparam int HYST_W      = 5;
   localparam int AGREE_W     = 8;
   localparam int HOT_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // sane window in 1/16 degree units, both ends excluded
   localparam logic signed [TEMP_W-1:0] SANE_LOW  = -16'sd320;
   localparam logic signed [TEMP_W-1:0] SANE_HIGH = 16'sd2080;

   localparam logic [DEG_W-1:0]   WARM_RESET  = 8'd60;
   localparam logic [DEG_W-1:0]   HOT_RESET   = 8'd75;
   localparam logic [DEG_W-1:0]   TRIP_RESET  = 8'd90;
   localparam logic [HYST_W-1:0]  HYST_RESET  = 5'd5;
   localparam logic [AGREE_W-1:0] AGREE_RESET = 8'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_WARM  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIP  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYST  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGREE = 3'd4;

   typedef enum logic [1:0] {
      LEVEL_OK   = 2'd0,
      LEVEL_WARM = 2'd1,
      LEVEL_HOT  = 2'd2,
      LEVEL_TRIP = 2'd3
   } level_type;

   typedef enum logic [1:0] {
      SIM_OFF  = 2'd0,
      SIM_WARM = 2'd1,
      SIM_HOT  = 2'd2,
      SIM_TRIP = 2'd3
   } sim_type;

   localparam logic ACTION_SAMPLE   = 1'b0;
   localparam logic ACTION_SIMULATE = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic                     action;
      logic                     have;
      logic signed [TEMP_W-1:0] board;
   } item_type;

   typedef struct packed {
      level_type                level;
      logic                     changed;
      logic signed [TEMP_W-1:0] board_temp;
      logic                     board_valid;
      logic                     simulated;
      logic [HOT_W-1:0]         hot_seconds;
   } result_type;

endpackage

/* hdl/tlg_front.sv */
// ----------------------------------------------------------------------------
// tlg_front
// Range-checks the two die readings and picks the hotter counted one.
// ----------------------------------------------------------------------------
module tlg_front (
   input  logic                             action,
   input  logic signed [tlg_pkg::TEMP_W-1:0] chip_temp,
   input  logic                             chip_valid,
   input  logic signed [tlg_pkg::TEMP_W-1:0] pmu_temp,
   input  logic                             pmu_valid,
   output tlg_pkg::item_type                item
);
   import tlg_pkg::*;

   logic chip_ok;
   logic pmu_ok;

   assign chip_ok = chip_valid && (chip_temp > SANE_LOW) && (chip_temp < SANE_HIGH);
   assign pmu_ok  = pmu_valid && (pmu_temp > SANE_LOW) && (pmu_temp < SANE_HIGH);

   always_comb begin
      item.action = action;
      item.have   = chip_ok || pmu_ok;
      if (pmu_ok && (!chip_ok || (pmu_temp > chip_temp))) begin
         item.board = pmu_temp;
      end else if (chip_ok) begin
         item.board = chip_temp;
      end else begin
         item.board = '0;
      end
   end

endmodule

/* hdl/tlg_queue.sv */
// ----------------------------------------------------------------------------
// tlg_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module tlg_queue #(
   parameter int DEPTH = tlg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlg_pkg::item_type push_item,
   output logic              full,
   output logic              valid,
   output tlg_pkg::item_type head,
   input  logic              pop
);
   import tlg_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      next_ptr = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full    = (count_ff == CW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/tlg_back.sv */
// ----------------------------------------------------------------------------
// tlg_back
// Holds the thresholds and the level state, applies the simulation
// override, hysteresis and debounce, and registers one result item.
// ----------------------------------------------------------------------------
module tlg_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tlg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tlg_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                q_valid,
   input  tlg_pkg::item_type                   q_item,
   output logic                                q_pop,
   output logic                                out_valid,
   output tlg_pkg::result_type                 out_result,
   input  logic                                out_pop
);
   import tlg_pkg::*;

   logic [DEG_W-1:0]   warm_ff, hot_ff, trip_ff;
   logic [HYST_W-1:0]  hyst_ff;
   logic [AGREE_W-1:0] agree_need_ff;

   level_type          cur_level_ff, cur_level_in;
   level_type          pend_level_ff, pend_level_in;
   logic [AGREE_W-1:0] agree_ff, agree_in;
   logic [HOT_W-1:0]   hot_count_ff, hot_count_in;
   sim_type            sim_ff, sim_in;
   logic signed [TEMP_W-1:0] last_temp_ff, last_temp_in;
   logic               last_valid_ff, last_valid_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic               fire;
   logic signed [TEMP_W-1:0] board;
   logic               have;
   level_type          up_level, down_level, want;
   logic [AGREE_W-1:0] count_next;
   logic               changed;

   function automatic logic signed [16:0] line_of(input logic [DEG_W-1:0] deg,
                                                  input logic [8:0] off);
      line_of = $signed({5'b0, deg, 4'b0}) - $signed({8'b0, off});
   endfunction

   function automatic level_type level_for(input logic signed [TEMP_W-1:0] t,
                                           input logic [DEG_W-1:0] wa,
                                           input logic [DEG_W-1:0] ho,
                                           input logic [DEG_W-1:0] tr,
                                           input logic [8:0] off);
      logic signed [16:0] t17;
      t17 = {t[TEMP_W-1], t};
      if (t17 >= line_of(tr, off)) begin
         level_for = LEVEL_TRIP;
      end else if (t17 >= line_of(ho, off)) begin
         level_for = LEVEL_HOT;
      end else if (t17 >= line_of(wa, off)) begin
         level_for = LEVEL_WARM;
      end else begin
         level_for = LEVEL_OK;
      end
   endfunction

   assign fire      = q_valid && (!out_valid_ff || out_pop);
   assign q_pop     = fire;
   assign out_valid = out_valid_ff;
   assign out_result = out_ff;

   // simulation override of the board temperature
   always_comb begin
      case (sim_ff)
         SIM_WARM: begin
            board = $signed({3'b0, {1'b0, warm_ff} + 9'd1, 4'b0});
            have  = 1'b1;
         end
         SIM_HOT: begin
            board = $signed({3'b0, {1'b0, hot_ff} + 9'd1, 4'b0});
            have  = 1'b1;
         end
         SIM_TRIP: begin
            board = $signed({3'b0, {1'b0, trip_ff} + 9'd1, 4'b0});
            have  = 1'b1;
         end
         default: begin
            board = q_item.board;
            have  = q_item.have;
         end
      endcase
   end

   always_comb begin
      up_level   = level_for(board, warm_ff, hot_ff, trip_ff, 9'd0);
      down_level = level_for(board, warm_ff, hot_ff, trip_ff, {hyst_ff, 4'b0});
      if (up_level > cur_level_ff) begin
         want = up_level;
      end else if (down_level < cur_level_ff) begin
         want = down_level;
      end else begin
         want = cur_level_ff;
      end
      if (want == pend_level_ff) begin
         count_next = (agree_ff == '1) ? agree_ff : agree_ff + 1'b1;
      end else begin
         count_next = AGREE_W'(1);
      end
   end

   always_comb begin
      cur_level_in  = cur_level_ff;
      pend_level_in = pend_level_ff;
      agree_in      = agree_ff;
      hot_count_in  = hot_count_ff;
      sim_in        = sim_ff;
      last_temp_in  = last_temp_ff;
      last_valid_in = last_valid_ff;
      changed       = 1'b0;
      out_valid_in  = out_valid_ff && !out_pop;
      out_in        = out_ff;

      if (fire) begin
         out_valid_in = 1'b1;
         if (q_item.action == ACTION_SIMULATE) begin
            sim_in = sim_type'(sim_ff + 2'd1);
         end else begin
            if (have) begin
               if (want != cur_level_ff) begin
                  pend_level_in = want;
                  agree_in      = count_next;
                  if (count_next >= agree_need_ff) begin
                     cur_level_in = want;
                     agree_in     = '0;
                     changed      = 1'b1;
                  end
               end else begin
                  agree_in = '0;
               end
            end
            // count up the hot count only at hot or above; below hot, clear it
            if (cur_level_in >= LEVEL_HOT) begin
               hot_count_in = (hot_count_ff == '1) ? hot_count_ff : hot_count_ff + 1'b1;
            end else begin
               hot_count_in = '0;
            end
            last_temp_in  = have ? board : '0;
            last_valid_in = have;
         end
         out_in.level       = cur_level_in;
         out_in.changed     = changed;
         out_in.board_temp  = last_temp_in;
         out_in.board_valid = last_valid_in;
         out_in.simulated   = (sim_in != SIM_OFF);
         out_in.hot_seconds = hot_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff       <= WARM_RESET;
         hot_ff        <= HOT_RESET;
         trip_ff       <= TRIP_RESET;
         hyst_ff       <= HYST_RESET;
         agree_need_ff <= AGREE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WARM:  warm_ff       <= csr_data;
            CSR_HOT:   hot_ff        <= csr_data;
            CSR_TRIP:  trip_ff       <= csr_data;
            CSR_HYST:  hyst_ff       <= csr_data[HYST_W-1:0];
            CSR_AGREE: agree_need_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_level_ff  <= LEVEL_OK;
         pend_level_ff <= LEVEL_OK;
         agree_ff      <= '0;
         hot_count_ff  <= '0;
         sim_ff        <= SIM_OFF;
         last_temp_ff  <= '0;
         last_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_level_ff  <= cur_level_in;
         pend_level_ff <= pend_level_in;
         agree_ff      <= agree_in;
         hot_count_ff  <= hot_count_in;
         sim_ff        <= sim_in;
         last_temp_ff  <= last_temp_in;
         last_valid_ff <= last_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   a_sim_keeps_level: assert property (@(posedge clock) disable iff (reset)
      fire && q_item.action |=>
         cur_level_ff == $past(cur_level_ff) && hot_count_ff == $past(hot_count_ff))
      else $error("simulate item disturbed level or hot count");

   a_hot_count_tracks_level: assert property (@(posedge clock) disable iff (reset)
      fire && !q_item.action |=> (cur_level_ff >= LEVEL_HOT) == (hot_count_ff != '0))
      else $error("hot count out of step with level");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(cur_level_ff) && $stable(agree_ff) && $stable(sim_ff))
      else $error("level state moved without an item");

   a_commit_clears_agree: assert property (@(posedge clock) disable iff (reset)
      fire |=> !out_ff.changed || agree_ff == '0)
      else $error("agree count not cleared on level change");

endmodule

/* hdl/thermal_level_guard_core.sv */
// ----------------------------------------------------------------------------
// thermal_level_guard_core
// Four-level thermal guard with hysteresis and sample debounce.
//
//   channel  ports                      accept at rising edge
//   -------  -------------------------  ----------------------
//   request  req_push / full / req_*    req_push && !full
//   response empty / rsp_pop / rsp_*    rsp_pop && !empty
//   csr      csr_write_en / index/data  csr_write_en
//
// One item per cycle sustained while responses are popped; an item passes
// the item queue, then the result register, on its way to the response ports.
// The level update is a combinational compare and debounce in the back end.
// Reset is synchronous; no clearing pass.
// A stalled response fills the queue, then full rises; while the result
// register drains with rsp_pop, a new item is taken in the same cycle.
// ----------------------------------------------------------------------------
module thermal_level_guard_core #(
   parameter int QUEUE_DEPTH = tlg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                full,
   input  logic                                req_action,
   input  logic signed [tlg_pkg::TEMP_W-1:0]   req_chip_temp,
   input  logic                                req_chip_valid,
   input  logic signed [tlg_pkg::TEMP_W-1:0]   req_pmu_temp,
   input  logic                                req_pmu_valid,
   output logic                                empty,
   input  logic                                rsp_pop,
   output logic [1:0]                          rsp_level,
   output logic                                rsp_changed,
   output logic signed [tlg_pkg::TEMP_W-1:0]   rsp_board_temp,
   output logic                                rsp_board_valid,
   output logic                                rsp_simulated,
   output logic [tlg_pkg::HOT_W-1:0]           rsp_hot_seconds,
   input  logic                                csr_write_en,
   input  logic [tlg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tlg_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tlg_pkg::*;

   item_type   front_item;
   item_type   q_head;
   logic       q_valid;
   logic       q_pop;
   logic       out_valid;
   result_type out_result;

   tlg_front u_front (
      .action     (req_action),
      .chip_temp  (req_chip_temp),
      .chip_valid (req_chip_valid),
      .pmu_temp   (req_pmu_temp),
      .pmu_valid  (req_pmu_valid),
      .item       (front_item)
   );

   tlg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (full),
      .valid     (q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   tlg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_valid      (q_valid),
      .q_item       (q_head),
      .q_pop        (q_pop),
      .out_valid    (out_valid),
      .out_result   (out_result),
      .out_pop      (rsp_pop)
   );

   assign empty           = !out_valid;
   assign rsp_level       = out_result.level;
   assign rsp_changed     = out_result.changed;
   assign rsp_board_temp  = out_result.board_temp;
   assign rsp_board_valid = out_result.board_valid;
   assign rsp_simulated   = out_result.simulated;
   assign rsp_hot_seconds = out_result.hot_seconds;

endmodule
